>>> src/spinor_pkg.sv
// ----------------------------------------------------------------------------
// SPI NOR command sequencer package
// Shared codes, step masks and the job record passed from front to back.
// ----------------------------------------------------------------------------
package spinor_pkg;

    localparam int ADDR_BITS   = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] MODE_READ_ID   = 3'd0;
    localparam logic [2:0] MODE_READ_DATA = 3'd1;
    localparam logic [2:0] MODE_ERASE     = 3'd2;
    localparam logic [2:0] MODE_PROGRAM   = 3'd3;
    localparam logic [2:0] MODE_STATUS    = 3'd4;
    localparam logic [2:0] MODE_PROG_BYTE = 3'd5;
    localparam logic [2:0] MODE_RX_BYTE   = 3'd6;

    localparam logic [2:0] ACT_SEND      = 3'd0;
    localparam logic [2:0] ACT_CLOCK_IN  = 3'd1;
    localparam logic [2:0] ACT_DESELECT  = 3'd2;
    localparam logic [2:0] ACT_HOST_BYTE = 3'd3;
    localparam logic [2:0] ACT_DONE      = 3'd4;

    localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;
    localparam logic [7:0] CMD_READ_ID      = 8'h9F;
    localparam logic [7:0] CMD_READ_DATA    = 8'h03;
    localparam logic [7:0] CMD_READ_STATUS  = 8'h05;
    localparam logic [7:0] CMD_SECTOR_ERASE = 8'hD8;
    localparam logic [7:0] CMD_PAGE_PROGRAM = 8'h02;

    localparam int STATUS_BUSY_BIT = 0;
    localparam int STATUS_FAIL_BIT = 5;

    localparam int STEP_WREN  = 0;
    localparam int STEP_WDES  = 1;
    localparam int STEP_CMD   = 2;
    localparam int STEP_A2    = 3;
    localparam int STEP_A1    = 4;
    localparam int STEP_A0    = 5;
    localparam int STEP_HOST  = 6;
    localparam int STEP_TDES  = 7;
    localparam int STEP_T05   = 8;
    localparam int STEP_TCLK  = 9;
    localparam int STEP_TDONE = 10;
    localparam int NUM_STEPS  = 11;

    typedef logic [NUM_STEPS-1:0] t_step_mask;

    localparam t_step_mask STEP_ONE    = t_step_mask'(1);
    localparam t_step_mask HEAD_WREN   = (STEP_ONE << STEP_WREN) | (STEP_ONE << STEP_WDES);
    localparam t_step_mask HEAD_CMD    = STEP_ONE << STEP_CMD;
    localparam t_step_mask HEAD_ADDR   = (STEP_ONE << STEP_A2) | (STEP_ONE << STEP_A1)
                                       | (STEP_ONE << STEP_A0);
    localparam t_step_mask HEAD_HOST   = STEP_ONE << STEP_HOST;
    localparam t_step_mask TAIL_CLOCK  = STEP_ONE << STEP_TCLK;
    localparam t_step_mask TAIL_POLL   = (STEP_ONE << STEP_TDES) | (STEP_ONE << STEP_T05)
                                       | (STEP_ONE << STEP_TCLK);
    localparam t_step_mask TAIL_FINISH = (STEP_ONE << STEP_TDES) | (STEP_ONE << STEP_TDONE);

    typedef struct packed {
        t_step_mask           mask;
        logic [7:0]           cmd_byte;
        logic [ADDR_BITS-1:0] address;
        logic                 fail;
        logic [15:0]          count;
    } t_job;

endpackage

>>> src/spi_nor_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Turns host requests and received flash bytes into SPI byte actions.
//
//   Channel   Direction  Request
//   s_axis    in         request or received byte (mode in tuser)
//   m_axis    out        one SPI or host action (action in tuser, tlast ends it)
//
// A request is taken whenever the job queue has room.
// The back end issues one action per cycle while the output is not stalled and
// a job is waiting; a request causes one to nine actions, and the queue depth
// sets how far the front end may run ahead.
// Reset is synchronous and clears the phase, the queue and the output valid.
// A stalled output holds its action while the front end keeps taking requests
// until the queue is full.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer #(
    parameter int P_QUEUE_DEPTH = spinor_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address [23:0], length [39:24], data_byte [47:40]
    input  logic [47:0] s_axis_tdata,
    // mode [2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // byte_value [7:0], erase_failed [8], byte_count [24:9], zero [31:25]
    output logic [31:0] m_axis_tdata,
    // action [2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import spinor_pkg::*;

    logic        w_accept, w_push, w_full, w_empty, w_pop;
    t_job        w_push_job, w_head_job;
    logic [7:0]  w_byte_value;
    logic        w_erase_failed;
    logic [15:0] w_byte_count;

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    spinor_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_mode      (s_axis_tuser),
        .i_address   (s_axis_tdata[23:0]),
        .i_length    (s_axis_tdata[39:24]),
        .i_data_byte (s_axis_tdata[47:40]),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    spinor_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    spinor_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_job          (w_head_job),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_action       (m_axis_tuser),
        .o_byte_value   (w_byte_value),
        .o_erase_failed (w_erase_failed),
        .o_byte_count   (w_byte_count),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, w_byte_count, w_erase_failed, w_byte_value};

    a_done_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ACT_DONE)) |-> m_axis_tlast)
        else $error("done action not marked last");

    a_count_only_on_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ACT_DONE)) |->
        ((m_axis_tdata[24:9] == 16'd0) && !m_axis_tdata[8]))
        else $error("count or failure flag set on a non-done action");

    a_pop_has_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job taken from an empty queue");

endmodule

>>> src/spinor_front.sv
// ----------------------------------------------------------------------------
// SPI NOR command sequencer front end
// Tracks the operation phase and turns each request into a job of steps.
// ----------------------------------------------------------------------------
module spinor_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [2:0]                      i_mode,
    input  logic [spinor_pkg::ADDR_BITS-1:0] i_address,
    input  logic [15:0]                     i_length,
    input  logic [7:0]                      i_data_byte,
    output logic                            o_push,
    output spinor_pkg::t_job                o_job
);
    import spinor_pkg::*;

    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_READING     = 3'd1;
    localparam logic [2:0] PH_PROGRAMMING = 3'd2;
    localparam logic [2:0] PH_POLLING     = 3'd3;
    localparam logic [2:0] PH_ERASE_CHECK = 3'd4;
    localparam logic [2:0] PH_STATUS_READ = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_op, n_op;
    logic [15:0] r_left, n_left;
    logic [15:0] r_done, n_done;
    logic [15:0] w_left_dec, w_done_inc;
    logic        w_idle, w_len_zero;
    t_job        w_job;

    assign w_left_dec = r_left - 16'd1;
    assign w_done_inc = r_done + 16'd1;
    assign w_idle     = (r_phase == PH_IDLE);
    assign w_len_zero = (i_length == 16'd0);

    always_comb begin
        n_phase        = r_phase;
        n_op           = r_op;
        n_left         = r_left;
        n_done         = r_done;
        w_job.mask     = '0;
        w_job.cmd_byte = '0;
        w_job.address  = i_address;
        w_job.fail     = 1'b0;
        w_job.count    = '0;
        unique case (i_mode)
            MODE_READ_ID, MODE_READ_DATA: begin
                if (w_idle) begin
                    n_op   = i_mode;
                    n_done = '0;
                    n_left = i_length;
                    w_job.mask = HEAD_CMD | ((i_mode == MODE_READ_DATA) ? HEAD_ADDR : '0)
                               | (w_len_zero ? TAIL_FINISH : TAIL_CLOCK);
                    w_job.cmd_byte = (i_mode == MODE_READ_ID) ? CMD_READ_ID : CMD_READ_DATA;
                    n_phase = w_len_zero ? PH_IDLE : PH_READING;
                end
            end
            MODE_ERASE: begin
                if (w_idle) begin
                    n_op           = i_mode;
                    n_done         = '0;
                    n_left         = '0;
                    w_job.mask     = HEAD_WREN | HEAD_CMD | HEAD_ADDR | TAIL_POLL;
                    w_job.cmd_byte = CMD_SECTOR_ERASE;
                    n_phase        = PH_POLLING;
                end
            end
            MODE_PROGRAM: begin
                if (w_idle) begin
                    n_op           = i_mode;
                    n_done         = '0;
                    n_left         = i_length;
                    w_job.mask     = HEAD_WREN | HEAD_CMD | HEAD_ADDR
                                   | (w_len_zero ? TAIL_POLL : '0);
                    w_job.cmd_byte = CMD_PAGE_PROGRAM;
                    n_phase        = w_len_zero ? PH_POLLING : PH_PROGRAMMING;
                end
            end
            MODE_STATUS: begin
                if (w_idle) begin
                    n_op           = i_mode;
                    n_done         = '0;
                    n_left         = '0;
                    w_job.mask     = HEAD_CMD | TAIL_CLOCK;
                    w_job.cmd_byte = CMD_READ_STATUS;
                    n_phase        = PH_STATUS_READ;
                end
            end
            MODE_PROG_BYTE: begin
                if (r_phase == PH_PROGRAMMING) begin
                    n_left         = w_left_dec;
                    n_done         = w_done_inc;
                    w_job.cmd_byte = i_data_byte;
                    if (w_left_dec == 16'd0) begin
                        w_job.mask = HEAD_CMD | TAIL_POLL;
                        n_phase    = PH_POLLING;
                    end else begin
                        w_job.mask = HEAD_CMD;
                    end
                end
            end
            MODE_RX_BYTE: begin
                unique case (r_phase)
                    PH_READING: begin
                        n_left         = w_left_dec;
                        n_done         = w_done_inc;
                        w_job.cmd_byte = i_data_byte;
                        if (w_left_dec == 16'd0) begin
                            w_job.mask  = HEAD_HOST | TAIL_FINISH;
                            w_job.count = w_done_inc;
                            n_phase     = PH_IDLE;
                        end else begin
                            w_job.mask = HEAD_HOST | TAIL_CLOCK;
                        end
                    end
                    PH_POLLING: begin
                        if (i_data_byte[STATUS_BUSY_BIT]) begin
                            w_job.mask = TAIL_POLL;
                        end else if (r_op == MODE_ERASE) begin
                            w_job.mask = TAIL_POLL;
                            n_phase    = PH_ERASE_CHECK;
                        end else begin
                            w_job.mask  = TAIL_FINISH;
                            w_job.count = r_done;
                            n_phase     = PH_IDLE;
                        end
                    end
                    PH_ERASE_CHECK: begin
                        w_job.mask  = TAIL_FINISH;
                        w_job.fail  = i_data_byte[STATUS_FAIL_BIT];
                        w_job.count = r_done;
                        n_phase     = PH_IDLE;
                    end
                    PH_STATUS_READ: begin
                        w_job.mask     = HEAD_HOST | TAIL_FINISH;
                        w_job.cmd_byte = i_data_byte;
                        w_job.count    = 16'd1;
                        n_done         = 16'd1;
                        n_phase        = PH_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_op    <= '0;
            r_left  <= '0;
            r_done  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_left  <= n_left;
            r_done  <= n_done;
        end
    end

    assign o_push = i_accept && (w_job.mask != '0);
    assign o_job  = w_job;

endmodule

>>> src/spinor_queue.sv
// ----------------------------------------------------------------------------
// SPI NOR command sequencer job queue
// Small first-in first-out store of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module spinor_queue #(
    parameter int DEPTH = spinor_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  spinor_pkg::t_job i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output spinor_pkg::t_job o_job
);
    import spinor_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
        next_ptr = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> src/spinor_back.sv
// ----------------------------------------------------------------------------
// SPI NOR command sequencer back end
// Walks the steps of each job and presents one action per cycle while the output is not stalled and a job is waiting.
// ----------------------------------------------------------------------------
module spinor_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  spinor_pkg::t_job i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_action,
    output logic [7:0]       o_byte_value,
    output logic             o_erase_failed,
    output logic [15:0]      o_byte_count,
    output logic             o_last
);
    import spinor_pkg::*;

    t_step_mask  r_mask, n_mask, w_cur_mask;
    t_job        r_job, w_cur;
    logic        r_valid;
    logic [2:0]  r_action, n_action;
    logic [7:0]  r_byte, n_byte;
    logic        r_fail, n_fail;
    logic [15:0] r_count, n_count;
    logic        r_last;
    logic        w_advance, w_from_queue, w_emit;

    assign w_from_queue = (r_mask == '0);
    assign w_cur        = w_from_queue ? i_job : r_job;
    assign w_cur_mask   = w_from_queue ? (i_empty ? '0 : i_job.mask) : r_mask;
    assign w_advance    = !r_valid || i_ready;
    assign w_emit       = w_advance && (w_cur_mask != '0);
    assign n_mask       = w_cur_mask & (w_cur_mask - t_step_mask'(1));
    assign o_pop        = w_emit && w_from_queue;

    always_comb begin
        n_action = ACT_SEND;
        n_byte   = '0;
        n_fail   = 1'b0;
        n_count  = '0;
        priority if (w_cur_mask[STEP_WREN]) begin
            n_byte = CMD_WRITE_ENABLE;
        end else if (w_cur_mask[STEP_WDES]) begin
            n_action = ACT_DESELECT;
        end else if (w_cur_mask[STEP_CMD]) begin
            n_byte = w_cur.cmd_byte;
        end else if (w_cur_mask[STEP_A2]) begin
            n_byte = w_cur.address[ADDR_BITS-1 -: 8];
        end else if (w_cur_mask[STEP_A1]) begin
            n_byte = w_cur.address[ADDR_BITS-9 -: 8];
        end else if (w_cur_mask[STEP_A0]) begin
            n_byte = w_cur.address[ADDR_BITS-17 -: 8];
        end else if (w_cur_mask[STEP_HOST]) begin
            n_action = ACT_HOST_BYTE;
            n_byte   = w_cur.cmd_byte;
        end else if (w_cur_mask[STEP_TDES]) begin
            n_action = ACT_DESELECT;
        end else if (w_cur_mask[STEP_T05]) begin
            n_byte = CMD_READ_STATUS;
        end else if (w_cur_mask[STEP_TCLK]) begin
            n_action = ACT_CLOCK_IN;
        end else begin
            n_action = ACT_DONE;
            n_fail   = w_cur.fail;
            n_count  = w_cur.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else if (w_advance) begin
            r_valid <= w_emit;
            if (w_emit) begin
                r_mask <= n_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_emit) begin
            r_action <= n_action;
            r_byte   <= n_byte;
            r_fail   <= n_fail;
            r_count  <= n_count;
            r_last   <= (n_mask == '0);
        end
    end

    assign o_valid        = r_valid;
    assign o_action       = r_action;
    assign o_byte_value   = r_byte;
    assign o_erase_failed = r_fail;
    assign o_byte_count   = r_count;
    assign o_last         = r_last;

endmodule

>>> bench/spi_seq_checker.sv
// ----------------------------------------------------------------------------
// SPI NOR command sequencer checker
// Watches both stream channels. Every accepted request is run through a
// model of the sequencer, and the actions it should cause are queued.
// Every accepted action is compared field by field with the oldest queued
// action. The mismatch count and the number of actions still awaited are
// handed to the bench top.
// ----------------------------------------------------------------------------
module spi_seq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // address [23:0], length [39:24], data_byte [47:40]
    input  logic [47:0] s_axis_tdata,
    // mode [2:0]
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // byte_value [7:0], erase_failed [8], byte_count [24:9], zero [31:25]
    input  logic [31:0] m_axis_tdata,
    // action [2:0]
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          o_mismatches,
    output int          o_pending
);
    import spinor_pkg::*;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_PROGRAM,
        SEQ_POLL,
        SEQ_ERASE_CHECK,
        SEQ_STATUS
    } t_seq_phase;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  value;
        logic        failed;
        logic [15:0] count;
        logic        last;
    } t_spi_action;

    t_spi_action expected_actions[$];
    t_spi_action staged_actions[$];

    t_seq_phase  phase;
    logic [2:0]  operation;
    logic [15:0] bytes_left;
    logic [15:0] bytes_done;
    int          mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch at %0t: %s is %0h, expected %0h", $time, field, got, want);
        mismatches++;
    endtask

    task automatic stage(input logic [2:0] action, input logic [7:0] value,
                         input logic failed, input logic [15:0] count);
        t_spi_action beat;
        beat.action = action;
        beat.value  = value;
        beat.failed = failed;
        beat.count  = count;
        beat.last   = 1'b0;
        staged_actions.push_back(beat);
    endtask

    task automatic stage_address(input logic [23:0] address);
        stage(ACT_SEND, address[23:16], 1'b0, 16'd0);
        stage(ACT_SEND, address[15:8], 1'b0, 16'd0);
        stage(ACT_SEND, address[7:0], 1'b0, 16'd0);
    endtask

    task automatic begin_status_poll();
        stage(ACT_DESELECT, 8'h00, 1'b0, 16'd0);
        stage(ACT_SEND, CMD_READ_STATUS, 1'b0, 16'd0);
        stage(ACT_CLOCK_IN, 8'h00, 1'b0, 16'd0);
        phase = SEQ_POLL;
    endtask

    task automatic finish_operation(input logic failed);
        stage(ACT_DESELECT, 8'h00, 1'b0, 16'd0);
        stage(ACT_DONE, 8'h00, failed, bytes_done);
        phase = SEQ_IDLE;
    endtask

    task automatic begin_read(input logic [15:0] length);
        bytes_left = length;
        bytes_done = 16'd0;
        if (length == 16'd0) begin
            finish_operation(1'b0);
        end else begin
            stage(ACT_CLOCK_IN, 8'h00, 1'b0, 16'd0);
            phase = SEQ_READ;
        end
    endtask

    task automatic predict_actions(input logic [2:0] mode, input logic [23:0] address,
                                   input logic [15:0] length, input logic [7:0] data_byte);
        staged_actions.delete();
        case (mode)
            MODE_READ_ID, MODE_READ_DATA, MODE_ERASE, MODE_PROGRAM, MODE_STATUS: begin
                if (phase == SEQ_IDLE) begin
                    operation  = mode;
                    bytes_done = 16'd0;
                    bytes_left = 16'd0;
                    case (mode)
                        MODE_READ_ID: begin
                            stage(ACT_SEND, CMD_READ_ID, 1'b0, 16'd0);
                            begin_read(length);
                        end
                        MODE_READ_DATA: begin
                            stage(ACT_SEND, CMD_READ_DATA, 1'b0, 16'd0);
                            stage_address(address);
                            begin_read(length);
                        end
                        MODE_ERASE: begin
                            stage(ACT_SEND, CMD_WRITE_ENABLE, 1'b0, 16'd0);
                            stage(ACT_DESELECT, 8'h00, 1'b0, 16'd0);
                            stage(ACT_SEND, CMD_SECTOR_ERASE, 1'b0, 16'd0);
                            stage_address(address);
                            begin_status_poll();
                        end
                        MODE_PROGRAM: begin
                            stage(ACT_SEND, CMD_WRITE_ENABLE, 1'b0, 16'd0);
                            stage(ACT_DESELECT, 8'h00, 1'b0, 16'd0);
                            stage(ACT_SEND, CMD_PAGE_PROGRAM, 1'b0, 16'd0);
                            stage_address(address);
                            bytes_left = length;
                            if (length == 16'd0) begin
                                begin_status_poll();
                            end else begin
                                phase = SEQ_PROGRAM;
                            end
                        end
                        default: begin
                            stage(ACT_SEND, CMD_READ_STATUS, 1'b0, 16'd0);
                            stage(ACT_CLOCK_IN, 8'h00, 1'b0, 16'd0);
                            phase = SEQ_STATUS;
                        end
                    endcase
                end
            end
            MODE_PROG_BYTE: begin
                if (phase == SEQ_PROGRAM) begin
                    stage(ACT_SEND, data_byte, 1'b0, 16'd0);
                    bytes_left = bytes_left - 16'd1;
                    bytes_done = bytes_done + 16'd1;
                    if (bytes_left == 16'd0) begin
                        begin_status_poll();
                    end
                end
            end
            MODE_RX_BYTE: begin
                case (phase)
                    SEQ_READ: begin
                        stage(ACT_HOST_BYTE, data_byte, 1'b0, 16'd0);
                        bytes_left = bytes_left - 16'd1;
                        bytes_done = bytes_done + 16'd1;
                        if (bytes_left == 16'd0) begin
                            finish_operation(1'b0);
                        end else begin
                            stage(ACT_CLOCK_IN, 8'h00, 1'b0, 16'd0);
                        end
                    end
                    SEQ_POLL: begin
                        if (data_byte[STATUS_BUSY_BIT]) begin
                            begin_status_poll();
                        end else if (operation == MODE_ERASE) begin
                            begin_status_poll();
                            phase = SEQ_ERASE_CHECK;
                        end else begin
                            finish_operation(1'b0);
                        end
                    end
                    SEQ_ERASE_CHECK: begin
                        finish_operation(data_byte[STATUS_FAIL_BIT]);
                    end
                    SEQ_STATUS: begin
                        stage(ACT_HOST_BYTE, data_byte, 1'b0, 16'd0);
                        bytes_done = 16'd1;
                        finish_operation(1'b0);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (staged_actions.size() > 0) begin
            staged_actions[staged_actions.size() - 1].last = 1'b1;
            foreach (staged_actions[i]) begin
                expected_actions.push_back(staged_actions[i]);
            end
        end
    endtask

    task automatic check_action();
        t_spi_action want;
        if (expected_actions.size() == 0) begin
            report("action with nothing awaited", {29'd0, m_axis_tuser}, 32'd0);
        end else begin
            want = expected_actions.pop_front();
            if (m_axis_tuser !== want.action) begin
                report("action", {29'd0, m_axis_tuser}, {29'd0, want.action});
            end
            if (m_axis_tdata[7:0] !== want.value) begin
                report("byte_value", {24'd0, m_axis_tdata[7:0]}, {24'd0, want.value});
            end
            if (m_axis_tdata[8] !== want.failed) begin
                report("erase_failed", {31'd0, m_axis_tdata[8]}, {31'd0, want.failed});
            end
            if (m_axis_tdata[24:9] !== want.count) begin
                report("byte_count", {16'd0, m_axis_tdata[24:9]}, {16'd0, want.count});
            end
            if (m_axis_tdata[31:25] !== 7'd0) begin
                report("padding", {25'd0, m_axis_tdata[31:25]}, 32'd0);
            end
            if (m_axis_tlast !== want.last) begin
                report("last", {31'd0, m_axis_tlast}, {31'd0, want.last});
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase      = SEQ_IDLE;
            operation  = MODE_READ_ID;
            bytes_left = 16'd0;
            bytes_done = 16'd0;
            expected_actions.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_actions(s_axis_tuser, s_axis_tdata[23:0], s_axis_tdata[39:24],
                                s_axis_tdata[47:40]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_action();
            end
        end
        o_pending <= expected_actions.size();
    end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// SPI NOR command sequencer bench
// Drives the sequencer with a short directed set of requests and then with
// random but well formed flash operations, each followed by the bytes the
// flash would return, mixed with requests the block should ignore. Sender
// gaps and receiver stalls vary by phase, and one long receiver hold-off
// lets the block fill up. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import spinor_pkg::*;

    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NOISE_PCT       = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 64;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = 48'd0;
    logic [2:0]  s_axis_tuser  = MODE_READ_ID;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int mismatches;
    int pending;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int receiver_hold      = 0;
    int sequence_items     = 0;

    always #5 i_clk = ~i_clk;

    spi_nor_flash_command_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    spi_seq_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        forever begin
            @(posedge i_clk);
            if (receiver_hold > 0) begin
                m_axis_tready <= 1'b0;
                receiver_hold--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    initial begin
        #2000000;
        $display("spi_nor_flash_command_sequencer regression: fail");
        $finish;
    end

    task automatic send_item(input logic [2:0] mode, input logic [23:0] address,
                             input logic [15:0] length, input logic [7:0] data_byte,
                             input bit counted);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 48'({$urandom(), $urandom()});
            s_axis_tuser  <= 3'($urandom());
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data_byte, length, address};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (counted) begin
            sequence_items++;
        end
    endtask

    function automatic logic [2:0] request_mode(input int pick);
        case (pick)
            0:       return MODE_READ_ID;
            1:       return MODE_READ_DATA;
            2:       return MODE_ERASE;
            3:       return MODE_PROGRAM;
            default: return MODE_STATUS;
        endcase
    endfunction

    // Sometimes sends a request that the current phase must ignore.
    task automatic maybe_ignored(input bit idle_now, input bit programming);
        logic [2:0] mode;
        int         pick;
        if ($urandom_range(99) < NOISE_PCT) begin
            if (idle_now) begin
                pick = $urandom_range(2);
                mode = (pick == 0) ? MODE_PROG_BYTE : (pick == 1) ? MODE_RX_BYTE : MODE_UNUSED;
            end else begin
                pick = $urandom_range(6);
                if (pick < 5) begin
                    mode = request_mode(pick);
                end else if (pick == 5) begin
                    mode = MODE_UNUSED;
                end else begin
                    mode = programming ? MODE_RX_BYTE : MODE_PROG_BYTE;
                end
            end
            send_item(mode, 24'($urandom()), 16'($urandom()), 8'($urandom()), 1'b0);
        end
    endtask

    task automatic send_rx(input logic [7:0] data_byte);
        maybe_ignored(1'b0, 1'b0);
        send_item(MODE_RX_BYTE, 24'($urandom()), 16'($urandom()), data_byte, 1'b1);
    endtask

    task automatic send_polls(input int busy_count);
        logic [7:0] status;
        repeat (busy_count) begin
            status = 8'($urandom());
            status[STATUS_BUSY_BIT] = 1'b1;
            send_rx(status);
        end
        status = 8'($urandom());
        status[STATUS_BUSY_BIT] = 1'b0;
        send_rx(status);
    endtask

    function automatic logic [15:0] pick_length();
        if ($urandom_range(19) == 0) begin
            return 16'($urandom_range(48, 16));
        end
        return 16'($urandom_range(6));
    endfunction

    task automatic run_read(input logic [2:0] mode, input logic [15:0] length);
        send_item(mode, 24'($urandom()), length, 8'($urandom()), 1'b1);
        repeat (length) begin
            send_rx(8'($urandom()));
        end
    endtask

    task automatic run_erase();
        logic [7:0] status;
        send_item(MODE_ERASE, 24'($urandom()), 16'($urandom()), 8'($urandom()), 1'b1);
        send_polls($urandom_range(3));
        status = 8'($urandom());
        send_rx(status);
    endtask

    task automatic run_program(input logic [15:0] length);
        send_item(MODE_PROGRAM, 24'($urandom()), length, 8'($urandom()), 1'b1);
        repeat (length) begin
            maybe_ignored(1'b0, 1'b1);
            send_item(MODE_PROG_BYTE, 24'($urandom()), 16'($urandom()), 8'($urandom()), 1'b1);
        end
        send_polls($urandom_range(3));
    endtask

    task automatic run_random_operation();
        maybe_ignored(1'b1, 1'b0);
        case ($urandom_range(8))
            0, 1:    run_read(MODE_READ_ID, pick_length());
            2, 3:    run_read(MODE_READ_DATA, pick_length());
            4:       run_erase();
            5, 6:    run_program(pick_length());
            default: begin
                send_item(MODE_STATUS, 24'($urandom()), 16'($urandom()), 8'($urandom()), 1'b1);
                send_rx(8'($urandom()));
            end
        endcase
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero-length read at the lowest address, then a three-byte ID read.
        send_item(MODE_READ_DATA, 24'h000000, 16'h0000, 8'h00, 1'b1);
        send_item(MODE_READ_ID, 24'hFFFFFF, 16'd3, 8'hFF, 1'b1);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'h00, 1'b1);
        send_item(MODE_RX_BYTE, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'hA5, 1'b1);
        // One-byte read at the top address with a program byte out of place.
        send_item(MODE_READ_DATA, 24'hFFFFFF, 16'd1, 8'h00, 1'b1);
        send_item(MODE_PROG_BYTE, 24'h000000, 16'h0000, 8'hFF, 1'b0);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'h5A, 1'b1);
        // Ignored items while idle.
        send_item(MODE_UNUSED, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b0);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'h00, 1'b0);
        send_item(MODE_PROG_BYTE, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b0);
        // Erase that polls busy once, sees a request while busy and fails.
        send_item(MODE_ERASE, 24'h123456, 16'h0000, 8'h00, 1'b1);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'hFF, 1'b1);
        send_item(MODE_READ_ID, 24'h000000, 16'hFFFF, 8'h00, 1'b0);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'h00, 1'b1);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'h20, 1'b1);
        // Erase at the top address that succeeds.
        send_item(MODE_ERASE, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'hFE, 1'b1);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'hDF, 1'b1);
        // Zero-length program goes straight to polling.
        send_item(MODE_PROGRAM, 24'h000000, 16'h0000, 8'h00, 1'b1);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'h00, 1'b1);
        // Two-byte program with a received byte out of place.
        send_item(MODE_PROGRAM, 24'hABCDEF, 16'd2, 8'h00, 1'b1);
        send_item(MODE_PROG_BYTE, 24'h000000, 16'h0000, 8'hFF, 1'b1);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'h00, 1'b0);
        send_item(MODE_PROG_BYTE, 24'h000000, 16'h0000, 8'h00, 1'b1);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'h01, 1'b1);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'h00, 1'b1);
        send_item(MODE_STATUS, 24'h000000, 16'h0000, 8'h00, 1'b1);
        send_item(MODE_RX_BYTE, 24'h000000, 16'h0000, 8'hFF, 1'b1);

        for (int stage_idx = 0; stage_idx < 4; stage_idx++) begin
            case (stage_idx)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    receiver_hold      = HOLD_OFF_CYCLES;
                end
                1: begin
                    sender_idle_pct    = 48;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 48;
                end
                default: begin
                    sender_idle_pct    = 7;
                    receiver_stall_pct = 7;
                end
            endcase
            while (sequence_items < (stage_idx + 1) * ITEMS_PER_PHASE) begin
                run_random_operation();
            end
        end

        s_axis_tvalid <= 1'b0;
        receiver_stall_pct = 0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("spi_nor_flash_command_sequencer regression: pass");
        end else begin
            $display("spi_nor_flash_command_sequencer regression: fail");
        end
        $finish;
    end

endmodule
